@@ src/itoa_pkg.sv @@
// Package for the integer to ASCII converter: sequencer states, ASCII codes
// and the digit glyph function. It depends on nothing else.
`default_nettype none

package itoa_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_SIGN,
    ST_EMIT
  } itoa_state_e;

  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiMinus = 8'h2D;

  localparam logic [4:0] RadixMin = 5'd2;
  localparam logic [4:0] RadixMax = 5'd16;
  localparam logic [4:0] RadixTen = 5'd10;

  function automatic logic [7:0] digit_glyph(input logic [3:0] d);
    logic [7:0] g;
    if (d < 4'd10) begin
      g = AsciiZero + {4'd0, d};
    end else begin
      g = AsciiUpperA + {4'd0, d} - 8'd10;
    end
    return g;
  endfunction

endpackage

`default_nettype wire

@@ src/integer_to_ascii_radix.sv @@
// Top level of the integer to ASCII converter: sequencer, shared divider step
// unit, digit store and output register. It depends on itoa_pkg.
`default_nettype none

// A transaction carries a 32-bit value, a radix (saturated to 2..16) and a
// kind; the block returns its ASCII digits most significant first, one
// character per output transaction, with last set on the final one. A
// negative value of signed kind in radix ten gives a leading minus sign.
// Digits are produced least significant first: in radices 2, 4, 8 and 16 by
// shift and mask, in the others by a shared compare-and-subtract unit that
// resolves four quotient bits a cycle. After the digits the store is read,
// the sign is sent if any, and then the characters follow one per cycle
// while the output is not stalled. The input is stalled for the whole
// conversion; the last character may still wait in the output register
// while the next transaction is taken.
module integer_to_ascii_radix #(
  parameter int MAX_DIGITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] value_i,
  input  wire logic [4:0]  radix_i,
  input  wire logic        kind_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       character_o,
  output logic             last_o
);
  import itoa_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);

  itoa_state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [AW-1:0] idx_q, idx_d;
  logic [2:0]    step_q, step_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    char_q, char_d;
  logic          last_q, last_d;

  logic [31:0] quot_q, quot_d;
  logic [3:0]  rem_q, rem_d;
  logic [4:0]  radix_q, radix_d;
  logic        pow2_q, pow2_d;
  logic [2:0]  sh_q, sh_d;
  logic        neg_q, neg_d;

  logic [3:0]    mem [MAX_DIGITS];
  logic [3:0]    rd_q;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr;
  logic [3:0]    wr_data;

  logic        accept, out_free;
  logic [4:0]  radix_sat;
  logic [31:0] div_q;
  logic [4:0]  div_r;
  logic [31:0] step_quot;
  logic [3:0]  step_digit;
  logic        digit_done, conv_done;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_inc  = cnt_q + CW'(1);

  always_comb begin
    if (radix_i < RadixMin) begin
      radix_sat = RadixMin;
    end else if (radix_i > RadixMax) begin
      radix_sat = RadixMax;
    end else begin
      radix_sat = radix_i;
    end
  end

  always_comb begin
    div_r = {1'b0, rem_q};
    div_q = quot_q;
    for (int i = 0; i < 4; i++) begin
      div_r = {div_r[3:0], div_q[31]};
      div_q = {div_q[30:0], 1'b0};
      if (div_r >= radix_q) begin
        div_r    = div_r - radix_q;
        div_q[0] = 1'b1;
      end
    end
  end

  always_comb begin
    if (pow2_q) begin
      step_quot  = quot_q >> sh_q;
      step_digit = quot_q[3:0] & ((4'd1 << sh_q) - 4'd1);
    end else begin
      step_quot  = div_q;
      step_digit = div_r[3:0];
    end
  end

  assign digit_done = pow2_q || (step_q == 3'd7);
  assign conv_done  = digit_done && ((step_quot == 32'd0) || (cnt_inc == CW'(MAX_DIGITS)));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (conv_done) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        state_d = neg_q ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (out_free) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && (idx_q == '0)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    step_d      = step_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    radix_d     = radix_q;
    pow2_d      = pow2_q;
    sh_d        = sh_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && out_stall_i;
    char_d      = char_q;
    last_d      = last_q;
    wr_en       = 1'b0;
    wr_data     = step_digit;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          radix_d = radix_sat;
          neg_d   = kind_i && (radix_sat == RadixTen) && value_i[31];
          quot_d  = (kind_i && (radix_sat == RadixTen) && value_i[31]) ? (32'd0 - value_i)
                                                                       : value_i;
          pow2_d  = (radix_sat == 5'd2) || (radix_sat == 5'd4) ||
                    (radix_sat == 5'd8) || (radix_sat == 5'd16);
          case (radix_sat)
            5'd2:    sh_d = 3'd1;
            5'd4:    sh_d = 3'd2;
            5'd8:    sh_d = 3'd3;
            default: sh_d = 3'd4;
          endcase
          rem_d  = 4'd0;
          step_d = 3'd0;
          cnt_d  = '0;
        end
      end
      ST_DIV: begin
        quot_d = step_quot;
        if (digit_done) begin
          wr_en  = 1'b1;
          cnt_d  = cnt_inc;
          idx_d  = cnt_q[AW-1:0];
          rem_d  = 4'd0;
          step_d = 3'd0;
        end else begin
          rem_d  = div_r[3:0];
          step_d = step_q + 3'd1;
        end
      end
      ST_FETCH: begin
        rd_en = 1'b1;
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = AsciiMinus;
          last_d      = 1'b0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = digit_glyph(rd_q);
          last_d      = (idx_q == '0);
          rd_en       = 1'b1;
          rd_addr     = idx_q - AW'(1);
          idx_d       = idx_q - AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q  <= quot_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    pow2_q  <= pow2_d;
    sh_q    <= sh_d;
    neg_q   <= neg_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

@@ src/itoa_chk.sv @@
// Port-level checker for the integer to ASCII converter and its bind to the
// top level. It depends on itoa_pkg and integer_to_ascii_radix.
`default_nettype none

module itoa_chk (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] character_o,
  input wire logic       last_o
);
  import itoa_pkg::*;

  // A conversion always occupies the block for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after a transaction");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(character_o) && $stable(last_o)))
    else $error("stalled output transaction changed");

  a_glyph: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((character_o >= AsciiZero && character_o <= 8'h39) ||
                     (character_o >= AsciiUpperA && character_o <= 8'h46) ||
                     (character_o == AsciiMinus)))
    else $error("output character is not a digit or minus sign");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (character_o == AsciiMinus)) |-> !last_o)
    else $error("minus sign marked as final character");

endmodule

bind integer_to_ascii_radix itoa_chk u_itoa_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .character_o (character_o),
  .last_o      (last_o)
);

`default_nettype wire
